/* sv/mbp2_pkg.sv */
// Shared constants, CORDIC tables and carry types for the power-2 Mandelbulb step.
// Used by the CORDIC units and by the top level; depends on nothing else.
package mbp2_pkg;

    localparam int CORDIC_STEPS = 24;

    // Datapath widths
    localparam int VW = 38;   // vectoring x/y
    localparam int AW = 34;   // vectoring angle (binary angle, full turn 2^32)
    localparam int CW = 34;   // rotation x/y and r
    localparam int ADDR_W = 5;

    // Register stages outside the three CORDIC chains plus the chains themselves
    localparam int NSTG = 10 + 3 * CORDIC_STEPS;

    localparam logic [29:0] INV_K = 30'd652032874;
    localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        REG_PRE_ABS  = 3'd0,
        REG_POST_ABS = 3'd1,
        REG_PHI_SCL  = 3'd2,
        REG_ADD_X    = 3'd3,
        REG_ADD_Y    = 3'd4,
        REG_ADD_Z    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [32:0] z;
        logic [63:0]        rr;
        logic [47:0]        de;
    } side_a_t;

    typedef struct packed {
        logic [31:0] phi2;
        logic [63:0] rr;
        logic [47:0] de;
    } side_b_t;

    typedef struct packed {
        logic [63:0] rr;
        logic [47:0] de;
    } side_r_t;

endpackage

/* sv/mbp2_vec_cordic.sv */
// Pipelined vectoring CORDIC: one iteration per register stage, half-turn fold in front.
// Returns the scaled magnitude and the binary angle; depends on mbp2_pkg.
module mbp2_vec_cordic (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic signed [mbp2_pkg::VW-1:0]  in_x,
    input  logic signed [mbp2_pkg::VW-1:0]  in_y,
    output logic signed [mbp2_pkg::VW-1:0]  out_mag,
    output logic signed [mbp2_pkg::AW-1:0]  out_ang
);
    import mbp2_pkg::*;

    logic signed [VW-1:0] x_reg [CORDIC_STEPS];
    logic signed [VW-1:0] y_reg [CORDIC_STEPS];
    logic signed [AW-1:0] a_reg [CORDIC_STEPS];
    logic                 zero_reg [CORDIC_STEPS];

    logic signed [VW-1:0] fx, fy;
    logic signed [AW-1:0] fa;
    logic                 fz;

    // Fold the left half-plane onto the right one
    always_comb begin
        fz = (in_x == '0) && (in_y == '0);
        if (in_x < 0) begin
            fa = (in_y >= 0) ? HALF_TURN : -HALF_TURN;
            fx = -in_x;
            fy = -in_y;
        end else begin
            fa = '0;
            fx = in_x;
            fy = in_y;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        localparam logic signed [AW-1:0] STEP_ANG = AW'(ATAN_TAB[i]);
        logic signed [VW-1:0] xi, yi;
        logic signed [AW-1:0] ai;
        logic                 zi;
        if (i == 0) begin : g_first
            assign xi = fx;
            assign yi = fy;
            assign ai = fa;
            assign zi = fz;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
            assign zi = zero_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (yi >= 0) begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    a_reg[i] <= ai + STEP_ANG;
                end else begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    a_reg[i] <= ai - STEP_ANG;
                end
                zero_reg[i] <= zi;
            end
        end
    end

    // Zero vector: force angle and magnitude to zero
    assign out_mag = zero_reg[CORDIC_STEPS-1] ? '0 : x_reg[CORDIC_STEPS-1];
    assign out_ang = zero_reg[CORDIC_STEPS-1] ? '0 : a_reg[CORDIC_STEPS-1];

endmodule

/* sv/mbp2_rot_cordic.sv */
// Pipelined rotation CORDIC: cosine and sine in Q30 of a 32-bit binary angle.
// One iteration per register stage, half-turn fold in front; depends on mbp2_pkg.
module mbp2_rot_cordic (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic [31:0]                     in_ang,
    output logic signed [mbp2_pkg::CW-1:0]  out_cos,
    output logic signed [mbp2_pkg::CW-1:0]  out_sin
);
    import mbp2_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS];
    logic signed [CW-1:0] r_reg [CORDIC_STEPS];
    logic                 flip_reg [CORDIC_STEPS];

    logic [31:0]          qsum, u;
    logic                 fflip;
    logic signed [CW-1:0] fr;

    // Fold angles outside [-quarter, quarter) by a half turn and negate later
    always_comb begin
        qsum  = in_ang + 32'h4000_0000;
        fflip = qsum[31];
        u     = fflip ? in_ang + 32'h8000_0000 : in_ang;
        fr    = CW'($signed(u));
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        localparam logic signed [CW-1:0] STEP_ANG = CW'(ATAN_TAB[i]);
        logic signed [CW-1:0] xi, yi, ri;
        logic                 fi;
        if (i == 0) begin : g_first
            assign xi = CW'(INV_K);
            assign yi = '0;
            assign ri = fr;
            assign fi = fflip;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ri = r_reg[i-1];
            assign fi = flip_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (ri >= 0) begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    r_reg[i] <= ri - STEP_ANG;
                end else begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    r_reg[i] <= ri + STEP_ANG;
                end
                flip_reg[i] <= fi;
            end
        end
    end

    assign out_cos = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
    assign out_sin = flip_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];

endmodule

/* sv/mandelbulb_power2_iteration.sv */
// Power-2 Mandelbulb iteration step: one point per cycle while m_tready allows, through a deep pipeline.
// Uses mbp2_pkg, mbp2_vec_cordic (two instances) and mbp2_rot_cordic (two instances).
//
// Input stream (s_*): one point per transaction, x/y/z in signed Q12.20, the running
// derivative in unsigned Q32.16 and the caller's radius. Output stream (m_*): the
// iterated point, saturated to 32-bit signed, and the derivative de*2*radius,
// saturated to 48 bits. Every input transaction gives exactly one output transaction.
// The data path from acceptance to m_tvalid runs through the stages T0 to T9 and
// two vectoring CORDIC chains and one rotation chain, one iteration per stage.
// Throughput is one transaction per cycle while m_tready stays high.
// All stages advance together; when the output register is full and m_tready is
// low, the whole pipeline holds and s_tready drops, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and restores the registers:
// masks 0, phi_scale 2.0 (4096), add constants 0.
// The APB port holds six registers at byte addresses 0, 4, ... 20; pready is always
// high. Write registers only while the pipeline is empty.
module mandelbulb_power2_iteration (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], dist_est[143:96], radius[174:144], pad
    input  logic [175:0]                  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // new_x[31:0], new_y[63:32], new_z[95:64], new_dist_est[143:96]
    output logic [143:0]                  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbp2_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mbp2_pkg::*;

    // ---------------- configuration ----------------
    logic [2:0]         pre_abs_reg, post_abs_reg;
    logic signed [15:0] phi_scale_reg;
    logic signed [31:0] add_x_reg, add_y_reg, add_z_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_abs_reg   <= '0;
            post_abs_reg  <= '0;
            phi_scale_reg <= 16'sd4096;
            add_x_reg     <= '0;
            add_y_reg     <= '0;
            add_z_reg     <= '0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_PRE_ABS:  pre_abs_reg   <= pwdata[2:0];
                REG_POST_ABS: post_abs_reg  <= pwdata[2:0];
                REG_PHI_SCL:  phi_scale_reg <= pwdata[15:0];
                REG_ADD_X:    add_x_reg     <= pwdata;
                REG_ADD_Y:    add_y_reg     <= pwdata;
                REG_ADD_Z:    add_z_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_PRE_ABS:  prdata = {29'd0, pre_abs_reg};
            REG_POST_ABS: prdata = {29'd0, post_abs_reg};
            REG_PHI_SCL:  prdata = 32'($signed(phi_scale_reg));
            REG_ADD_X:    prdata = add_x_reg;
            REG_ADD_Y:    prdata = add_y_reg;
            REG_ADD_Z:    prdata = add_z_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic [NSTG-1:0] vld_reg;
    logic            adv, s_accept;

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_accept};
        end
    end

    // ---------------- T0: capture ----------------
    logic signed [31:0] in_x_reg, in_y_reg, in_z_reg;
    logic [47:0]        in_de_reg;
    logic [30:0]        in_rad_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_x_reg   <= s_tdata[31:0];
            in_y_reg   <= s_tdata[63:32];
            in_z_reg   <= s_tdata[95:64];
            in_de_reg  <= s_tdata[143:96];
            in_rad_reg <= s_tdata[174:144];
        end
    end

    // ---------------- T1: abs, squares, derivative partial products ----------------
    logic signed [32:0] xa_next, ya_next, za_next;
    logic signed [65:0] sqx_next, sqy_next, sqz_next;
    logic signed [32:0] xa_reg, ya_reg, za_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [62:0]        de_lo_reg;
    logic [46:0]        de_hi_reg;

    always_comb begin
        xa_next = 33'(in_x_reg);
        ya_next = 33'(in_y_reg);
        za_next = 33'(in_z_reg);
        if (pre_abs_reg[0] && xa_next < 0) xa_next = -xa_next;
        if (pre_abs_reg[1] && ya_next < 0) ya_next = -ya_next;
        if (pre_abs_reg[2] && za_next < 0) za_next = -za_next;
        sqx_next = xa_next * xa_next;
        sqy_next = ya_next * ya_next;
        sqz_next = za_next * za_next;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xa_reg    <= xa_next;
            ya_reg    <= ya_next;
            za_reg    <= za_next;
            sqx_reg   <= sqx_next[63:0];
            sqy_reg   <= sqy_next[63:0];
            sqz_reg   <= sqz_next[63:0];
            de_lo_reg <= 63'(in_rad_reg) * 63'(in_de_reg[31:0]);
            de_hi_reg <= 47'(in_rad_reg) * 47'(in_de_reg[47:32]);
        end
    end

    // ---------------- T2: radius squared, derivative sum and saturate ----------------
    logic [78:0]        de_full;
    logic [59:0]        de_shr;
    logic signed [32:0] x2_reg, y2_reg, z2_reg;
    logic [63:0]        rr2_reg;
    logic [47:0]        de2_reg;

    assign de_full = {de_hi_reg, 32'd0} + 79'(de_lo_reg);
    assign de_shr  = de_full[78:19];

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg  <= xa_reg;
            y2_reg  <= ya_reg;
            z2_reg  <= za_reg;
            rr2_reg <= sqx_reg + sqy_reg + sqz_reg;
            de2_reg <= (|de_shr[59:48]) ? 48'hFFFF_FFFF_FFFF : de_shr[47:0];
        end
    end

    // ---------------- azimuth: atan2(y, x) and planar length ----------------
    logic signed [VW-1:0] va_x, va_y, lk_a;
    logic signed [AW-1:0] phi_a;
    side_a_t              side_a_reg [CORDIC_STEPS];

    assign va_x = VW'(x2_reg);
    assign va_y = VW'(y2_reg);

    mbp2_vec_cordic u_vec_phi (
        .aclk    (aclk),
        .adv     (adv),
        .in_x    (va_x),
        .in_y    (va_y),
        .out_mag (lk_a),
        .out_ang (phi_a)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_a_reg[0] <= '{z: z2_reg, rr: rr2_reg, de: de2_reg};
            for (int i = 1; i < CORDIC_STEPS; i++) side_a_reg[i] <= side_a_reg[i-1];
        end
    end

    // ---------------- T3/T4: length gain correction and phi scaling ----------------
    logic [63:0]           lkp_reg;
    logic signed [AW+15:0] phip_reg;
    side_a_t               s3_reg, s4_reg;
    logic [33:0]           len4_reg;
    logic [31:0]           phi2_4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lkp_reg    <= 64'(lk_a[33:0]) * 64'(INV_K);
            phip_reg   <= phi_a * phi_scale_reg;
            s3_reg     <= side_a_reg[CORDIC_STEPS-1];
            len4_reg   <= lkp_reg[63:30];
            phi2_4_reg <= phip_reg[42:11];
            s4_reg     <= s3_reg;
        end
    end

    // ---------------- polar angle: atan2(len, z) ----------------
    logic signed [VW-1:0] vb_x, vb_y, vb_mag;
    logic signed [AW-1:0] theta_b;
    side_b_t              side_b_reg [CORDIC_STEPS];

    assign vb_x = VW'(s4_reg.z);
    assign vb_y = $signed(VW'(len4_reg));

    mbp2_vec_cordic u_vec_theta (
        .aclk    (aclk),
        .adv     (adv),
        .in_x    (vb_x),
        .in_y    (vb_y),
        .out_mag (vb_mag),
        .out_ang (theta_b)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_b_reg[0] <= '{phi2: phi2_4_reg, rr: s4_reg.rr, de: s4_reg.de};
            for (int i = 1; i < CORDIC_STEPS; i++) side_b_reg[i] <= side_b_reg[i-1];
        end
    end

    // ---------------- sin/cos of 2*theta and 2*phi ----------------
    logic [31:0]          ang_t;
    logic signed [CW-1:0] c2t, s2t, c2p, s2p;
    side_r_t              side_r_reg [CORDIC_STEPS];

    // theta*2 wraps modulo a full turn
    assign ang_t = {theta_b[30:0], 1'b0};

    mbp2_rot_cordic u_rot_theta (
        .aclk    (aclk),
        .adv     (adv),
        .in_ang  (ang_t),
        .out_cos (c2t),
        .out_sin (s2t)
    );

    mbp2_rot_cordic u_rot_phi (
        .aclk    (aclk),
        .adv     (adv),
        .in_ang  (side_b_reg[CORDIC_STEPS-1].phi2),
        .out_cos (c2p),
        .out_sin (s2p)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_r_reg[0] <= '{rr: side_b_reg[CORDIC_STEPS-1].rr,
                               de: side_b_reg[CORDIC_STEPS-1].de};
            for (int i = 1; i < CORDIC_STEPS; i++) side_r_reg[i] <= side_r_reg[i-1];
        end
    end

    // ---------------- T5: trig products ----------------
    logic signed [2*CW-1:0] prx_reg, pry_reg;
    logic signed [CW-1:0]   c5_reg;
    side_r_t                s5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prx_reg <= s2t * c2p;
            pry_reg <= s2t * s2p;
            c5_reg  <= c2t;
            s5_reg  <= side_r_reg[CORDIC_STEPS-1];
        end
    end

    // ---------------- T6: floor to Q30, split sign and magnitude ----------------
    logic signed [CW-1:0] px6, py6, apx, apy, apz;
    logic [31:0]          ax6_reg, ay6_reg, az6_reg;
    logic [2:0]           neg6_reg;
    side_r_t              s6_reg;

    assign px6 = prx_reg[30+CW-1:30];
    assign py6 = pry_reg[30+CW-1:30];
    assign apx = (px6 < 0) ? -px6 : px6;
    assign apy = (py6 < 0) ? -py6 : py6;
    assign apz = (c5_reg < 0) ? -c5_reg : c5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax6_reg  <= apx[31:0];
            ay6_reg  <= apy[31:0];
            az6_reg  <= apz[31:0];
            neg6_reg <= {c5_reg < 0, py6 < 0, px6 < 0};
            s6_reg   <= s5_reg;
        end
    end

    // ---------------- T7: |p| * rr partial products ----------------
    logic [63:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg, lo_z_reg, hi_z_reg;
    logic [2:0]  neg7_reg;
    logic [47:0] de7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_x_reg <= 64'(ax6_reg) * 64'(s6_reg.rr[31:0]);
            hi_x_reg <= 64'(ax6_reg) * 64'(s6_reg.rr[63:32]);
            lo_y_reg <= 64'(ay6_reg) * 64'(s6_reg.rr[31:0]);
            hi_y_reg <= 64'(ay6_reg) * 64'(s6_reg.rr[63:32]);
            lo_z_reg <= 64'(az6_reg) * 64'(s6_reg.rr[31:0]);
            hi_z_reg <= 64'(az6_reg) * 64'(s6_reg.rr[63:32]);
            neg7_reg <= neg6_reg;
            de7_reg  <= s6_reg.de;
        end
    end

    // ---------------- T8: combine, shift by 50, cap at 2^40 ----------------
    function automatic logic [40:0] scale_cap(input logic [63:0] lo, input logic [63:0] hi);
        logic [64:0] sum;
        logic [46:0] shr;
        sum = 65'(hi) + 65'(lo[63:32]);
        shr = sum[64:18];
        scale_cap = (shr > 47'h100_0000_0000) ? 41'h100_0000_0000 : shr[40:0];
    endfunction

    logic [40:0] mx8_reg, my8_reg, mz8_reg;
    logic [2:0]  neg8_reg;
    logic [47:0] de8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mx8_reg  <= scale_cap(lo_x_reg, hi_x_reg);
            my8_reg  <= scale_cap(lo_y_reg, hi_y_reg);
            mz8_reg  <= scale_cap(lo_z_reg, hi_z_reg);
            neg8_reg <= neg7_reg;
            de8_reg  <= de7_reg;
        end
    end

    // ---------------- T9: sign, optional abs, add constant, saturate ----------------
    function automatic logic [31:0] finish(input logic [40:0] m, input logic neg,
                                           input logic post, input logic signed [31:0] addc);
        logic signed [42:0] v, s;
        v = $signed({2'b00, m});
        if (neg && !post) v = -v;
        s = v + 43'(addc);
        if (s > 43'sd2147483647)       finish = 32'h7FFF_FFFF;
        else if (s < -43'sd2147483648) finish = 32'h8000_0000;
        else                           finish = s[31:0];
    endfunction

    logic [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [47:0] out_de_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg  <= finish(mx8_reg, neg8_reg[0], post_abs_reg[0], add_x_reg);
            out_y_reg  <= finish(my8_reg, neg8_reg[1], post_abs_reg[1], add_y_reg);
            out_z_reg  <= finish(mz8_reg, neg8_reg[2], post_abs_reg[2], add_z_reg);
            out_de_reg <= de8_reg;
        end
    end

    assign m_tdata = {out_de_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

/* sv/mbp2_checker.sv */
// Port-level assertions for the Mandelbulb step block, attached by bind.
// Depends only on the top level's ports.
module mbp2_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         pready
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled output blocks new input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // Hold a stalled transaction
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind mandelbulb_power2_iteration mbp2_checker u_mbp2_checker (.*);
